>>> rtl/bclru_pkg.sv
// ----------------------------------------------------------------------------
// bclru_pkg
// Shared constants and types for the budgeted priority/LRU slot cache.
// ----------------------------------------------------------------------------
package bclru_pkg;

   localparam int SLOTS       = 16;
   localparam int SLOT_W      = $clog2(SLOTS);
   localparam int SIDE_W      = 14;
   localparam int MAX_SIDE    = 8192;
   localparam int PRIO_LEVELS = 4;
   localparam int PRIO_W      = 2;
   localparam int OP_W        = 3;

   localparam logic [31:0] DEFAULT_BUDGET = 32'd67108864;

   localparam logic [OP_W-1:0] OP_ENABLE  = 3'd0;
   localparam logic [OP_W-1:0] OP_DISABLE = 3'd1;
   localparam logic [OP_W-1:0] OP_ENSURE  = 3'd2;
   localparam logic [OP_W-1:0] OP_TOUCH   = 3'd3;
   localparam logic [OP_W-1:0] OP_TICK    = 3'd4;

   localparam logic [PRIO_W-1:0] PRIO_MAX = PRIO_W'(PRIO_LEVELS - 1);

   typedef struct packed {
      logic [SIDE_W-1:0] buf_width;
      logic [SIDE_W-1:0] buf_height;
      logic [PRIO_W-1:0] prio;
      logic [31:0]       stamp;
   } entry_type;

endpackage

>>> rtl/budget_cache_priority_lru_evictor.sv
// ----------------------------------------------------------------------------
// budget_cache_priority_lru_evictor
// Slot table of cached pixel buffers kept under a byte budget, evicting by
// priority then least recent use.
// ----------------------------------------------------------------------------
// The req_ channel carries one operation per transaction (enable, disable,
// ensure size, touch, tick). Each one produces a run of rsp_ transactions:
// a notice (kind 0) for every buffer freed, then one status (kind 1, last).
// Per-slot geometry, priority and stamp sit in a 16-entry synchronous
// memory; valid/registered flags are flip-flops.
// Sequencing: enable, touch, tick and ensures refused for an unregistered slot
// or a bad size go from acceptance through the execute and status states to
// the output register; a freed buffer adds a free state and its notice. An
// ensure that must evict runs a victim scan over the memory read port, then
// evicts the chosen victim, emits its notice and checks the fit again.
// req_ready is high only between operations.
// Results are held in an output register; while the receiver stalls the
// sequencer waits and accepts nothing new.
// Reset clears the flags, the byte count, the frame count and sets the
// budget to 64 MiB; the memory itself needs no clearing pass.
// ----------------------------------------------------------------------------
module budget_cache_priority_lru_evictor (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_opcode,
   input  logic [3:0]  req_slot,
   input  logic [1:0]  req_priority_req,
   input  logic [13:0] req_width,
   input  logic [13:0] req_height,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_kind,
   output logic [3:0]  rsp_freed_slot,
   output logic        rsp_ok,
   output logic [31:0] rsp_used_total,
   output logic [4:0]  rsp_live_entries,
   output logic        rsp_last,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int SW = bclru_pkg::SLOT_W;
   localparam int HW = bclru_pkg::SIDE_W;
   localparam int PW = bclru_pkg::PRIO_W;
   localparam int NS = bclru_pkg::SLOTS;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_EXEC  = 4'd1;
   localparam logic [3:0] S_FREE  = 4'd2;
   localparam logic [3:0] S_NEED  = 4'd3;
   localparam logic [3:0] S_FIT   = 4'd4;
   localparam logic [3:0] S_CHK   = 4'd5;
   localparam logic [3:0] S_SCAN  = 4'd6;
   localparam logic [3:0] S_VICT  = 4'd7;
   localparam logic [3:0] S_EVICT = 4'd8;
   localparam logic [3:0] S_EMIT  = 4'd9;
   localparam logic [3:0] S_STAT  = 4'd10;

   // slot memory
   bclru_pkg::entry_type mem [NS];
   bclru_pkg::entry_type rdata_ff;
   bclru_pkg::entry_type wr_data;
   logic [SW-1:0]        rd_addr;
   logic [SW-1:0]        wr_addr;
   logic                 wr_en;

   logic [3:0]      state_ff, state_in, ret_ff, ret_in;
   logic [2:0]      op_ff;
   logic [SW-1:0]   slot_ff;
   logic [PW-1:0]   prio_ff;
   logic [HW-1:0]   w_ff, h_ff;
   logic [NS-1:0]   reg_ff, reg_in, hb_ff, hb_in;
   logic [31:0]     used_ff, used_in, frame_ff, frame_in, budget_ff;
   logic [2*HW-1:0] prod_ff, prod_in;
   logic [2*HW+1:0] need_ff, need_in;
   logic [PW-1:0]   own_prio_ff, own_prio_in;
   logic [SW:0]     scan_ff, scan_in;
   logic [SW-1:0]   cmp_idx_ff;
   logic            cmp_vld_ff, cmp_vld_in;
   logic            found_ff, found_in;
   logic [SW-1:0]   bidx_ff, bidx_in;
   logic [PW-1:0]   bprio_ff, bprio_in;
   logic [31:0]     bstamp_ff, bstamp_in;
   logic [HW-1:0]   bw_ff, bw_in, bh_ff, bh_in;
   logic            em_kind_ff, em_kind_in, em_ok_ff, em_ok_in, fin_ok_ff, fin_ok_in;
   logic [SW-1:0]   em_slot_ff, em_slot_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            rsp_kind_ff, rsp_ok_ff, rsp_last_ff;
   logic [SW-1:0]   rsp_slot_ff;
   logic [31:0]     rsp_used_ff;
   logic [4:0]      rsp_live_ff;
   logic            rsp_load;

   logic [HW-1:0]   mul_a, mul_b;
   logic [2*HW+1:0] freed_bytes;
   logic [32:0]     fit_sum;
   logic            accept, cand, better, bad_size;
   logic [PW-1:0]   sat_prio;
   logic [4:0]      live;

   assign accept      = req_valid && req_ready;
   assign req_ready   = (state_ff == S_IDLE);
   assign freed_bytes = {prod_ff, 2'b00};
   assign fit_sum     = {1'b0, used_ff} + 33'(need_ff);
   assign live        = 5'($countones(reg_ff & hb_ff));
   assign sat_prio    = (prio_ff > bclru_pkg::PRIO_MAX) ? bclru_pkg::PRIO_MAX : prio_ff;
   assign bad_size    = (w_ff == '0) || (h_ff == '0)
                        || (32'(w_ff) > 32'(bclru_pkg::MAX_SIDE))
                        || (32'(h_ff) > 32'(bclru_pkg::MAX_SIDE));
   assign rsp_load    = (state_ff == S_EMIT) && (!rsp_valid_ff || rsp_ready);

   // victim candidate under compare this cycle
   assign cand   = cmp_vld_ff && hb_ff[cmp_idx_ff] && reg_ff[cmp_idx_ff]
                   && (cmp_idx_ff != slot_ff);
   assign better = !found_ff || (rdata_ff.prio < bprio_ff)
                   || ((rdata_ff.prio == bprio_ff) && (rdata_ff.stamp < bstamp_ff));

   always_comb begin
      case (state_ff)
         S_IDLE:  rd_addr = req_slot;
         S_SCAN:  rd_addr = scan_ff[SW-1:0];
         default: rd_addr = slot_ff;
      endcase
   end

   always_comb begin
      state_in    = state_ff;
      ret_in      = ret_ff;
      reg_in      = reg_ff;
      hb_in       = hb_ff;
      used_in     = used_ff;
      frame_in    = frame_ff;
      prod_in     = prod_ff;
      need_in     = need_ff;
      own_prio_in = own_prio_ff;
      scan_in     = scan_ff;
      cmp_vld_in  = 1'b0;
      found_in    = found_ff;
      bidx_in     = bidx_ff;
      bprio_in    = bprio_ff;
      bstamp_in   = bstamp_ff;
      bw_in       = bw_ff;
      bh_in       = bh_ff;
      em_kind_in  = em_kind_ff;
      em_ok_in    = em_ok_ff;
      em_slot_in  = em_slot_ff;
      fin_ok_in   = fin_ok_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      wr_en       = 1'b0;
      wr_addr     = slot_ff;
      wr_data     = rdata_ff;
      mul_a       = rdata_ff.buf_width;
      mul_b       = rdata_ff.buf_height;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in  = S_STAT;
            fin_ok_in = 1'b0;
            prod_in   = (2*HW)'(mul_a) * (2*HW)'(mul_b);
            case (op_ff)
               bclru_pkg::OP_TICK: begin
                  frame_in  = frame_ff + 32'd1;
                  fin_ok_in = 1'b1;
               end
               bclru_pkg::OP_ENABLE: begin
                  wr_en        = 1'b1;
                  wr_data.prio = sat_prio;
                  reg_in[slot_ff] = 1'b1;
                  fin_ok_in    = 1'b1;
               end
               bclru_pkg::OP_DISABLE: begin
                  if (reg_ff[slot_ff]) begin
                     reg_in[slot_ff] = 1'b0;
                     fin_ok_in       = 1'b1;
                     if (hb_ff[slot_ff]) begin
                        state_in = S_FREE;
                     end
                  end
               end
               bclru_pkg::OP_TOUCH: begin
                  if (reg_ff[slot_ff]) begin
                     wr_en         = 1'b1;
                     wr_data.stamp = frame_ff;
                     fin_ok_in     = 1'b1;
                  end
               end
               bclru_pkg::OP_ENSURE: begin
                  own_prio_in = rdata_ff.prio;
                  if (!reg_ff[slot_ff] || bad_size) begin
                     fin_ok_in = 1'b0;
                  end else if (hb_ff[slot_ff] && (rdata_ff.buf_width == w_ff)
                               && (rdata_ff.buf_height == h_ff)) begin
                     fin_ok_in = 1'b1;
                  end else if (hb_ff[slot_ff]) begin
                     state_in = S_FREE;
                  end else begin
                     state_in = S_NEED;
                  end
               end
               default: begin
                  fin_ok_in = 1'b0;
               end
            endcase
         end
         S_FREE: begin
            used_in        = (32'(freed_bytes) < used_ff) ? used_ff - 32'(freed_bytes) : '0;
            hb_in[slot_ff] = 1'b0;
            em_kind_in     = 1'b0;
            em_ok_in       = 1'b0;
            em_slot_in     = slot_ff;
            ret_in         = (op_ff == bclru_pkg::OP_ENSURE) ? S_NEED : S_STAT;
            state_in       = S_EMIT;
         end
         S_NEED: begin
            mul_a    = w_ff;
            mul_b    = h_ff;
            prod_in  = (2*HW)'(mul_a) * (2*HW)'(mul_b);
            state_in = S_FIT;
         end
         S_FIT: begin
            need_in = freed_bytes;
            if (32'(freed_bytes) > budget_ff) begin
               fin_ok_in = 1'b0;
               state_in  = S_STAT;
            end else begin
               state_in  = S_CHK;
            end
         end
         S_CHK: begin
            if (fit_sum <= {1'b0, budget_ff}) begin
               wr_en              = 1'b1;
               wr_data.buf_width  = w_ff;
               wr_data.buf_height = h_ff;
               wr_data.prio       = own_prio_ff;
               wr_data.stamp      = frame_ff;
               hb_in[slot_ff]     = 1'b1;
               used_in            = fit_sum[31:0];
               fin_ok_in          = 1'b1;
               state_in           = S_STAT;
            end else begin
               scan_in  = '0;
               found_in = 1'b0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (cand && better) begin
               found_in  = 1'b1;
               bidx_in   = cmp_idx_ff;
               bprio_in  = rdata_ff.prio;
               bstamp_in = rdata_ff.stamp;
               bw_in     = rdata_ff.buf_width;
               bh_in     = rdata_ff.buf_height;
            end
            if (scan_ff == (SW+1)'(NS)) begin
               state_in = S_VICT;
            end else begin
               cmp_vld_in = 1'b1;
               scan_in    = scan_ff + 1'b1;
            end
         end
         S_VICT: begin
            mul_a   = bw_ff;
            mul_b   = bh_ff;
            prod_in = (2*HW)'(mul_a) * (2*HW)'(mul_b);
            if (!found_ff) begin
               fin_ok_in = 1'b0;
               state_in  = S_STAT;
            end else begin
               state_in  = S_EVICT;
            end
         end
         S_EVICT: begin
            used_in        = (32'(freed_bytes) < used_ff) ? used_ff - 32'(freed_bytes) : '0;
            hb_in[bidx_ff] = 1'b0;
            em_kind_in     = 1'b0;
            em_ok_in       = 1'b0;
            em_slot_in     = bidx_ff;
            ret_in         = S_CHK;
            state_in       = S_EMIT;
         end
         S_STAT: begin
            em_kind_in = 1'b1;
            em_ok_in   = fin_ok_ff;
            em_slot_in = '0;
            ret_in     = S_IDLE;
            state_in   = S_EMIT;
         end
         S_EMIT: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               state_in     = ret_ff;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rdata_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ret_ff       <= S_IDLE;
         reg_ff       <= '0;
         hb_ff        <= '0;
         used_ff      <= '0;
         frame_ff     <= '0;
         budget_ff    <= bclru_pkg::DEFAULT_BUDGET;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         reg_ff       <= reg_in;
         hb_ff        <= hb_in;
         used_ff      <= used_in;
         frame_ff     <= frame_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_psel && csr_penable && csr_pwrite && (csr_paddr == 2'd0)) begin
            budget_ff <= csr_pwdata;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= req_opcode;
         slot_ff <= req_slot;
         prio_ff <= req_priority_req;
         w_ff    <= req_width;
         h_ff    <= req_height;
      end
      prod_ff     <= prod_in;
      need_ff     <= need_in;
      own_prio_ff <= own_prio_in;
      scan_ff     <= scan_in;
      cmp_idx_ff  <= scan_ff[SW-1:0];
      found_ff    <= found_in;
      bidx_ff     <= bidx_in;
      bprio_ff    <= bprio_in;
      bstamp_ff   <= bstamp_in;
      bw_ff       <= bw_in;
      bh_ff       <= bh_in;
      em_kind_ff  <= em_kind_in;
      em_ok_ff    <= em_ok_in;
      em_slot_ff  <= em_slot_in;
      fin_ok_ff   <= fin_ok_in;
      if (rsp_load) begin
         rsp_kind_ff <= em_kind_ff;
         rsp_slot_ff <= em_slot_ff;
         rsp_ok_ff   <= em_ok_ff;
         rsp_used_ff <= used_ff;
         rsp_live_ff <= live;
         rsp_last_ff <= em_kind_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_freed_slot   = rsp_slot_ff;
   assign rsp_ok           = rsp_ok_ff;
   assign rsp_used_total   = rsp_used_ff;
   assign rsp_live_entries = rsp_live_ff;
   assign rsp_last         = rsp_last_ff;
   assign csr_prdata       = budget_ff;
   assign csr_pready       = 1'b1;

endmodule

>>> rtl/bclru_checker.sv
// ----------------------------------------------------------------------------
// bclru_checker
// Port-level checks for the budgeted slot cache.
// ----------------------------------------------------------------------------
module bclru_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_kind,
   input logic [3:0]  rsp_freed_slot,
   input logic        rsp_ok,
   input logic [31:0] rsp_used_total,
   input logic        rsp_last
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_used_total) && $stable(rsp_kind))
      else $error("stalled result changed");

   // one operation at a time
   a_one_op: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_kind == rsp_last))
      else $error("last flag differs from status kind");

   a_notice_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_kind |-> !rsp_ok)
      else $error("free notice with ok set");

   a_status_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind |-> (rsp_freed_slot == 4'd0))
      else $error("status transaction carries a slot");

endmodule

bind budget_cache_priority_lru_evictor bclru_checker u_bclru_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_kind       (rsp_kind),
   .rsp_freed_slot (rsp_freed_slot),
   .rsp_ok         (rsp_ok),
   .rsp_used_total (rsp_used_total),
   .rsp_last       (rsp_last)
);
